>>> rtl/core/reed_solomon_parity_encoder_defines.svh
// assertion macros for the reed-solomon parity encoder checker
// expects clk and arst_n to be visible where a macro is used
`ifndef REED_SOLOMON_PARITY_ENCODER_DEFINES_SVH
`define REED_SOLOMON_PARITY_ENCODER_DEFINES_SVH

// same-cycle implication
`define RSP_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsp checker: same-cycle property violated");

// next-cycle implication
`define RSP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsp checker: next-cycle property violated");

`endif

>>> rtl/core/rsp_pkg.sv
// shared types, register codes and gf(256) helpers for the rs parity encoder
// no dependencies
`default_nettype none

package rsp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       is_parity;
		logic       last_of_run;
	} out_item_t;

	// generator builder status seen by the front and back parts
	typedef struct packed {
		logic       busy;
		logic [7:0] field_poly;
	} gen_status_t;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_EC_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FIELD_POLY = 2'd1;

	localparam logic [5:0] EC_COUNT_RESET   = 6'd5;
	localparam logic [7:0] FIELD_POLY_RESET = 8'h1D;

	localparam logic [7:0] GF_ONE   = 8'h01;
	localparam logic [7:0] GF_ALPHA = 8'h02;

	// multiply by x, reduce by x^8 + poly
	function automatic logic [7:0] gf_xtime(input logic [7:0] a, input logic [7:0] poly);
		return {a[6:0], 1'b0} ^ (a[7] ? poly : 8'h00);
	endfunction

	// shift-and-add product, eight narrow steps
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x, poly);
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/rsp_front.sv
// front part: takes requests from the input side into a two-entry queue
// depends on rsp_pkg
`default_nettype none

module rsp_front import rsp_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  in_item_t    item,
	input  gen_status_t status,
	output logic        q_valid,
	output in_item_t    q_item,
	input  wire         q_take
);

	in_item_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       acc;

	// no requests while the generator is being rebuilt
	assign full    = (cnt_q == 2'd2) || status.busy;
	assign acc     = push && !full;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wr_q <= !wr_q;
			end
			if (q_take) begin
				rd_q <= !rd_q;
			end
			case ({acc, q_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rsp_gen.sv
// configuration registers and generator polynomial builder
// depends on rsp_pkg; one root multiplied in per cycle
`default_nettype none

module rsp_gen import rsp_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	input  wire  [CFG_INDEX_W-1:0]         cfg_index,
	input  wire  [CFG_DATA_W-1:0]          cfg_data,
	output gen_status_t                    status,
	output logic [$clog2(MAX_PARITY+1)-1:0] n,
	output logic [7:0]                     coeffs [MAX_PARITY]
);

	localparam int NW = $clog2(MAX_PARITY + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_BUILD = 2'd2;

	logic [1:0]    state_q;
	logic [5:0]    ec_q;
	logic [7:0]    fpoly_q;
	logic [7:0]    poly_q [MAX_PARITY+1];
	logic [7:0]    root_q;
	logic [NW-1:0] left_q;
	logic          cfg_hit;

	// zero counts as one, large counts saturate
	always_comb begin
		if (ec_q == 6'd0) begin
			n = NW'(1);
		end else if (int'(ec_q) > MAX_PARITY) begin
			n = NW'(MAX_PARITY);
		end else begin
			n = NW'(ec_q);
		end
	end

	assign status.busy       = (state_q != ST_IDLE);
	assign status.field_poly = fpoly_q;

	// a write to a listed register restarts the build
	assign cfg_hit = cfg_valid && ((cfg_index == REG_EC_COUNT) || (cfg_index == REG_FIELD_POLY));

	always_comb begin
		for (int k = 0; k < MAX_PARITY; k++) begin
			coeffs[k] = poly_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ec_q    <= EC_COUNT_RESET;
			fpoly_q <= FIELD_POLY_RESET;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_EC_COUNT:   ec_q    <= cfg_data[5:0];
					REG_FIELD_POLY: fpoly_q <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_hit) begin
				state_q <= ST_LOAD;
			end else begin
				unique case (state_q)
					ST_IDLE:  state_q <= ST_IDLE;
					ST_LOAD:  state_q <= ST_BUILD;
					ST_BUILD: begin
						if (left_q == NW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
					default:  state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// load starts the product at one; each build step multiplies it by (x + root)
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			poly_q[0] <= GF_ONE;
			for (int k = 1; k <= MAX_PARITY; k++) begin
				poly_q[k] <= 8'h00;
			end
			root_q <= GF_ALPHA;
			left_q <= n;
		end else if (state_q == ST_BUILD) begin
			poly_q[0] <= gf_mul(poly_q[0], root_q, fpoly_q);
			for (int k = 1; k <= MAX_PARITY; k++) begin
				poly_q[k] <= poly_q[k-1] ^ gf_mul(poly_q[k], root_q, fpoly_q);
			end
			root_q <= gf_xtime(root_q, fpoly_q);
			left_q <= left_q - NW'(1);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rsp_back.sv
// back part: division register, parity drain and two-entry result queue
// depends on rsp_pkg
`default_nettype none

module rsp_back import rsp_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  gen_status_t                      status,
	input  wire  [$clog2(MAX_PARITY+1)-1:0]  n,
	input  wire  [7:0]                       coeffs [MAX_PARITY],
	input  wire                              q_valid,
	input  in_item_t                         q_item,
	output logic                             q_take,
	output logic                             empty,
	input  wire                              pop,
	output out_item_t                        result
);

	localparam int NW = $clog2(MAX_PARITY + 1);
	localparam int IW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

	localparam logic ST_DATA   = 1'b0;
	localparam logic ST_PARITY = 1'b1;

	logic          state_q;
	logic [NW-1:0] left_q;
	logic [7:0]    rem_q [MAX_PARITY];
	logic [IW-1:0] top;
	logic [7:0]    fb;
	logic          emit;

	out_item_t     omem_q [2];
	logic          owr_q;
	logic          ord_q;
	logic [1:0]    ocnt_q;
	logic          ofree;
	logic          opush;
	logic          opop;
	out_item_t     onew;

	assign top   = IW'(n - NW'(1));
	assign fb    = q_item.data_byte ^ rem_q[top];
	assign ofree = (ocnt_q != 2'd2);

	assign q_take = (state_q == ST_DATA) && q_valid && ofree && !status.busy;
	assign emit   = (state_q == ST_PARITY) && ofree;
	assign opush  = q_take || emit;
	assign opop   = pop && !empty;

	always_comb begin
		if (q_take) begin
			onew.code_byte   = q_item.data_byte;
			onew.is_parity   = 1'b0;
			onew.last_of_run = 1'b0;
		end else begin
			onew.code_byte   = rem_q[top];
			onew.is_parity   = 1'b1;
			onew.last_of_run = (left_q == NW'(1));
		end
	end

	// parity leaves from the top, zeros shift in at the bottom
	always_ff @(posedge clk) begin
		if (status.busy) begin
			for (int k = 0; k < MAX_PARITY; k++) begin
				rem_q[k] <= 8'h00;
			end
		end else if (q_take) begin
			rem_q[0] <= gf_mul(fb, coeffs[0], status.field_poly);
			for (int k = 1; k < MAX_PARITY; k++) begin
				rem_q[k] <= rem_q[k-1] ^ gf_mul(fb, coeffs[k], status.field_poly);
			end
		end else if (emit) begin
			rem_q[0] <= 8'h00;
			for (int k = 1; k < MAX_PARITY; k++) begin
				rem_q[k] <= rem_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
			left_q  <= '0;
		end else begin
			unique case (state_q)
				ST_DATA: begin
					if (q_take && q_item.end_of_message) begin
						state_q <= ST_PARITY;
						left_q  <= n;
					end
				end
				ST_PARITY: begin
					if (emit) begin
						left_q <= left_q - NW'(1);
						if (left_q == NW'(1)) begin
							state_q <= ST_DATA;
						end
					end
				end
				default: state_q <= ST_DATA;
			endcase
		end
	end

	// result queue
	assign empty  = (ocnt_q == 2'd0);
	assign result = omem_q[ord_q];

	always_ff @(posedge clk) begin
		if (opush) begin
			omem_q[owr_q] <= onew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) begin
				owr_q <= !owr_q;
			end
			if (opop) begin
				ord_q <= !ord_q;
			end
			case ({opush, opop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/reed_solomon_parity_encoder.sv
// top level of the systematic reed-solomon parity encoder over gf(256)
// depends on rsp_pkg, rsp_front, rsp_gen, rsp_back
//
// channel   direction  handshake                 payload
// input     in         push / full               item   (in_item_t)
// result    out        empty / pop               result (out_item_t)
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// data codewords stream at one per cycle while full is low, each passed through
// the input queue and then the result queue. an end-of-message codeword holds the
// back part while the n parity bytes drain, one per cycle while there is room,
// through the two-entry result queue. full stays high after reset and after each
// write to a listed register while the generator builder loads, one root per cycle.
// a stalled result side fills the result queue, then the input queue, then full.
`default_nettype none

module reed_solomon_parity_encoder import rsp_pkg::*; #(
	parameter int MAX_PARITY = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	output logic                  full,
	input  in_item_t              item,
	output logic                  empty,
	input  wire                   pop,
	output out_item_t             result,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [CFG_INDEX_W-1:0] cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	localparam int NW = $clog2(MAX_PARITY + 1);

	gen_status_t status;
	logic [NW-1:0] n;
	logic [7:0]  coeffs [MAX_PARITY];
	logic        q_valid;
	in_item_t    q_item;
	logic        q_take;

	assign cfg_ready = 1'b1;

	rsp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.status  (status),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take)
	);

	rsp_gen #(
		.MAX_PARITY (MAX_PARITY)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.n         (n),
		.coeffs    (coeffs)
	);

	rsp_back #(
		.MAX_PARITY (MAX_PARITY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.status  (status),
		.n       (n),
		.coeffs  (coeffs),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

>>> rtl/core/rsp_checker.sv
// port-level checks for the reed-solomon parity encoder, bound to the top level
// depends on rsp_pkg and reed_solomon_parity_encoder_defines.svh
`default_nettype none

`include "reed_solomon_parity_encoder_defines.svh"

module rsp_checker import rsp_pkg::*; (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   full,
	input wire                   empty,
	input wire                   pop,
	input out_item_t             result,
	input wire                   cfg_valid,
	input wire                   cfg_ready,
	input wire [CFG_INDEX_W-1:0] cfg_index
);

	// the end-of-run mark only ever rides on a parity byte
	`RSP_ASSERT_NOW(a_last_is_parity, !empty && result.last_of_run, result.is_parity)

	// a write to a listed register starts a rebuild, which blocks new requests
	`RSP_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready && (cfg_index == REG_EC_COUNT || cfg_index == REG_FIELD_POLY), full)

	// a waiting result stays put until taken
	`RSP_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result))

endmodule

bind reed_solomon_parity_encoder rsp_checker u_rsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.result    (result),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);

`default_nettype wire

>>> dv/reed_solomon_parity_encoder_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the reed-solomon parity encoder: a clocked driver and
// monitor around i_dut, with a gf(256) division-register predictor kept in step
// depends on rsp_pkg and reed_solomon_parity_encoder

module reed_solomon_parity_encoder_tb;
	import rsp_pkg::*;

	localparam int MAX_PARITY  = 32;
	localparam int CYCLE_LIMIT = 300000;
	localparam int IDLE_PCT    = 37;
	localparam int HOLD_CYCLES = 160;
	localparam int RANDOM_ITEMS = 300;

	// indexes past the register list, writes there are ignored
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   push      = 1'b0;
	in_item_t               item      = '0;
	logic                   pop       = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   full;
	logic                   empty;
	out_item_t              result;
	logic                   cfg_ready;

	// predictor state
	logic [5:0] cfg_ec;
	logic [7:0] cfg_poly;
	logic [7:0] div_reg [MAX_PARITY];
	logic [7:0] gen_poly [MAX_PARITY];

	in_item_t  pending_words [$];
	out_item_t expected_codes [$];

	int  errors      = 0;
	int  cycles      = 0;
	int  hold_left   = 0;
	bit  hold_done   = 1'b0;
	bit  no_gaps     = 1'b0;
	int  random_sent = 0;

	reed_solomon_parity_encoder #(
		.MAX_PARITY(MAX_PARITY)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] poly);
		logic [8:0] sh;
		logic [7:0] acc;
		acc = 8'h00;
		sh  = {1'b0, a};
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ sh[7:0];
			end
			sh = sh << 1;
			if (sh[8]) begin
				sh = {1'b0, sh[7:0] ^ poly};
			end
		end
		return acc;
	endfunction

	function automatic int parity_len();
		int n;
		n = cfg_ec;
		if (n < 1) begin
			n = 1;
		end
		if (n > MAX_PARITY) begin
			n = MAX_PARITY;
		end
		return n;
	endfunction

	// product of (x + a^i) for i = 1..n, monic term dropped
	task automatic build_generator();
		logic [7:0] p [MAX_PARITY + 1];
		logic [7:0] root;
		int n;
		n    = parity_len();
		root = GF_ONE;
		for (int k = 0; k <= MAX_PARITY; k++) begin
			p[k] = 8'h00;
		end
		p[0] = GF_ONE;
		for (int i = 1; i <= n; i++) begin
			root = gf_product(root, GF_ALPHA, cfg_poly);
			for (int k = i; k > 0; k--) begin
				p[k] = p[k - 1] ^ gf_product(p[k], root, cfg_poly);
			end
			p[0] = gf_product(p[0], root, cfg_poly);
		end
		for (int k = 0; k < MAX_PARITY; k++) begin
			gen_poly[k] = (k < n) ? p[k] : 8'h00;
			div_reg[k]  = 8'h00;
		end
	endtask

	task automatic set_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		if (idx == REG_EC_COUNT) begin
			cfg_ec = val[5:0];
			build_generator();
		end else if (idx == REG_FIELD_POLY) begin
			cfg_poly = val;
			build_generator();
		end
	endtask

	// one data codeword through the division register, parity queued on end of message
	task automatic encode_codeword(input in_item_t w);
		out_item_t o;
		logic [7:0] fb;
		int n;
		n  = parity_len();
		fb = w.data_byte ^ div_reg[n - 1];
		for (int k = n - 1; k > 0; k--) begin
			div_reg[k] = div_reg[k - 1] ^ gf_product(fb, gen_poly[k], cfg_poly);
		end
		div_reg[0] = gf_product(fb, gen_poly[0], cfg_poly);
		o.code_byte   = w.data_byte;
		o.is_parity   = 1'b0;
		o.last_of_run = 1'b0;
		expected_codes = {expected_codes, o};
		if (w.end_of_message) begin
			for (int k = 0; k < n; k++) begin
				o.code_byte   = div_reg[n - 1 - k];
				o.is_parity   = 1'b1;
				o.last_of_run = (k == n - 1);
				expected_codes = {expected_codes, o};
			end
			for (int k = 0; k < MAX_PARITY; k++) begin
				div_reg[k] = 8'h00;
			end
		end
	endtask

	// driver: one request per accepted push
	always @(posedge clk) begin : drive_words
		bit taken;
		if (arst_n) begin
			taken = push && !full;
			if (taken) begin
				encode_codeword(item);
			end
			if (!push || taken) begin
				if (pending_words.size() > 0 &&
						(no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
					item <= pending_words.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each popped result with the oldest expectation
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_codes.size() == 0) begin
					$error("unexpected result: code_byte %02h is_parity %0b last_of_run %0b",
						result.code_byte, result.is_parity, result.last_of_run);
					errors++;
				end else begin
					want = expected_codes.pop_front();
					if (result.code_byte !== want.code_byte) begin
						$error("code_byte: expected %02h, actual %02h",
							want.code_byte, result.code_byte);
						errors++;
					end
					if (result.is_parity !== want.is_parity) begin
						$error("is_parity: expected %0b, actual %0b",
							want.is_parity, result.is_parity);
						errors++;
					end
					if (result.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, actual %0b",
							want.last_of_run, result.last_of_run);
						errors++;
					end
				end
			end
			// one long hold-off while the sender still has plenty queued
			if (!hold_done && pending_words.size() >= 30) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		set_register(idx, val);
	endtask

	// sender holds until every expected result has come
	task automatic drain();
		while (pending_words.size() > 0 || push || expected_codes.size() > 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic add_word(input logic [7:0] d, input logic eom);
		in_item_t w;
		w.data_byte      = d;
		w.end_of_message = eom;
		pending_words = {pending_words, w};
	endtask

	task automatic add_message(input int len, input bit terminate);
		for (int i = 0; i < len; i++) begin
			add_word(8'($urandom_range(0, 255)), terminate && (i == len - 1));
		end
	endtask

	task automatic add_noise(input int len);
		for (int i = 0; i < len; i++) begin
			add_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		end
	endtask

	function automatic int message_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
	endfunction

	task automatic fill_chunk(input int target, input bit leave_open);
		int start;
		int len;
		start = pending_words.size();
		while (pending_words.size() - start < target) begin
			len = message_len();
			if ($urandom_range(0, 9) < 8) begin
				add_message(len, 1'b1);
			end else begin
				add_noise(len);
			end
		end
		if (leave_open) begin
			add_message($urandom_range(1, 5), 1'b0);
		end
		random_sent += pending_words.size() - start;
	endtask

	task automatic random_config();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			write_reg(REG_EC_COUNT,
				8'($urandom_range(1, 32)) | (8'($urandom_range(0, 3)) << 6));
		end else if (pick < 8) begin
			write_reg(REG_EC_COUNT, 8'($urandom_range(0, 255)));
		end
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			write_reg(REG_FIELD_POLY, FIELD_POLY_RESET);
		end else if (pick < 5) begin
			write_reg(REG_FIELD_POLY, ($urandom_range(0, 1) == 0) ? 8'h87 : 8'h2B);
		end else if (pick < 8) begin
			write_reg(REG_FIELD_POLY, 8'($urandom_range(0, 255)));
		end else begin
			write_reg(REG_EC_COUNT, 8'($urandom_range(1, 32)));
		end
		if ($urandom_range(0, 5) == 0) begin
			write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
				8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int phase;
		cfg_ec   = EC_COUNT_RESET;
		cfg_poly = FIELD_POLY_RESET;
		build_generator();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset generator, extremes of the data byte
		add_word(8'h00, 1'b0);
		add_word(8'hFF, 1'b0);
		add_word(8'hAA, 1'b0);
		add_word(8'h55, 1'b1);
		add_word(8'h80, 1'b1);
		add_word(8'h01, 1'b0);
		add_word(8'hFE, 1'b1);
		drain();

		// zero parity count acts as one
		write_reg(REG_EC_COUNT, 8'h00);
		add_word(8'hFF, 1'b1);
		add_word(8'h12, 1'b0);
		add_word(8'h34, 1'b1);
		drain();

		// upper data bits masked, then saturation above the maximum
		write_reg(REG_EC_COUNT, 8'hE1);
		add_word(8'hC3, 1'b0);
		add_word(8'h3C, 1'b1);
		drain();
		write_reg(REG_EC_COUNT, 8'h20);
		add_word(8'h7F, 1'b1);
		drain();
		write_reg(REG_EC_COUNT, 8'h3F);
		add_word(8'h01, 1'b1);
		drain();

		// degenerate field polynomials
		write_reg(REG_EC_COUNT, 8'h04);
		write_reg(REG_FIELD_POLY, 8'h00);
		add_word(8'hFF, 1'b0);
		add_word(8'h80, 1'b1);
		drain();
		write_reg(REG_FIELD_POLY, 8'hFF);
		add_word(8'hFF, 1'b0);
		add_word(8'h80, 1'b1);
		drain();

		// writes past the register list leave a message in progress alone
		add_word(8'h11, 1'b0);
		drain();
		write_reg(REG_SPARE_2, 8'hAA);
		write_reg(REG_SPARE_3, 8'h55);
		add_word(8'h22, 1'b1);
		drain();

		write_reg(REG_EC_COUNT, 8'h01);
		write_reg(REG_FIELD_POLY, FIELD_POLY_RESET);
		add_word(8'h00, 1'b1);
		drain();

		// a register write abandons the open message
		add_word(8'h9A, 1'b0);
		add_word(8'hBC, 1'b0);
		drain();
		write_reg(REG_EC_COUNT, 8'h06);
		add_word(8'hDE, 1'b1);
		drain();

		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (phase == 0) begin
				write_reg(REG_EC_COUNT, 8'h20);
				write_reg(REG_FIELD_POLY, FIELD_POLY_RESET);
			end else begin
				random_config();
			end
			no_gaps = (phase == 2);
			fill_chunk($urandom_range(30, 45), 1'b0);
			drain();
			fill_chunk($urandom_range(8, 20), $urandom_range(0, 2) == 0);
			drain();
			phase++;
		end
		no_gaps = 1'b0;

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_codes.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
